### rtl/soc_pkg.sv
// soc_pkg: shared widths, constants, queue record and arctangent table for
// the segment obstacle cost block. No dependencies.
`default_nettype none

package soc_pkg;

   // Internal widths, sized for the widest coordinate setting (24 bits)
   localparam int DIFF_W   = 25;   // coordinate difference
   localparam int PROD_W   = 50;   // signed product of two differences
   localparam int WIDE_W   = 52;   // l2, cross, dot
   localparam int CROSS_W  = 50;   // |cross|
   localparam int ROOT_W   = 32;   // segment length, 7 fraction bits
   localparam int DQ_W     = 58;   // distance, 8 fraction bits
   localparam int NUM_W    = 64;   // dividend / radicand shift register
   localparam int DEN_W    = 66;   // divisor
   localparam int REM_W    = 67;   // partial remainder
   localparam int VEC_W    = 62;   // CORDIC vector components
   localparam int ANG_W    = 28;   // angles, 24 fraction bits
   localparam int THETA_W  = 27;   // angle difference, non-negative
   localparam int SCALE_W  = 10;
   localparam int COST_W   = 32;
   localparam int CNT_W    = 7;
   localparam int ANG_IDX_W = 5;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 64;
   localparam int ANG_STEPS  = 24;
   localparam int MUL_STEPS  = 6;

   // Length is sqrt(l2 * 2^14), distance is |cross| * 2^15 / length
   localparam int LEN_SHIFT  = 14;
   localparam int DIST_SHIFT = 15;

   // Reference cost scale: 2^-16 per metre
   localparam int COST_REF = 16;
   localparam logic [SCALE_W-1:0] MM_PER_M = SCALE_W'(1000);

   // Vector normalisation limits: coarse steps of 8 below 2^49, then fine
   localparam int NORM_COARSE_SH = 8;
   localparam logic [VEC_W-1:0] NORM_COARSE = VEC_W'(1) << 49;
   localparam logic [VEC_W-1:0] NORM_TARGET = VEC_W'(1) << 57;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   // Queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   typedef struct packed {
      logic [CROSS_W-1:0]       cross_mag;
      logic signed [WIDE_W-1:0] dot;
      logic signed [WIDE_W-1:0] len_sq;
      logic                     degenerate;
      logic                     first;
      logic                     last;
   } soc_job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } soc_q_status_type;

   // atan(2^-i) in radians, 24 fraction bits
   function automatic logic signed [ANG_W-1:0] arc_at(input logic [ANG_IDX_W-1:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         5'd0:  v = ANG_W'(13176795);
         5'd1:  v = ANG_W'(7778716);
         5'd2:  v = ANG_W'(4110060);
         5'd3:  v = ANG_W'(2086331);
         5'd4:  v = ANG_W'(1047214);
         5'd5:  v = ANG_W'(524117);
         5'd6:  v = ANG_W'(262123);
         5'd7:  v = ANG_W'(131069);
         5'd8:  v = ANG_W'(65536);
         5'd9:  v = ANG_W'(32768);
         5'd10: v = ANG_W'(16384);
         5'd11: v = ANG_W'(8192);
         5'd12: v = ANG_W'(4096);
         5'd13: v = ANG_W'(2048);
         5'd14: v = ANG_W'(1024);
         5'd15: v = ANG_W'(512);
         5'd16: v = ANG_W'(256);
         5'd17: v = ANG_W'(128);
         5'd18: v = ANG_W'(64);
         5'd19: v = ANG_W'(32);
         5'd20: v = ANG_W'(16);
         5'd21: v = ANG_W'(8);
         5'd22: v = ANG_W'(4);
         5'd23: v = ANG_W'(2);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/segment_obstacle_cost.sv
// segment_obstacle_cost: top level; front part, job queue and back part.
// An item passes the front, the queue, a square root, a divide, a normalising shift
// and a CORDIC pass for each of two vectors, a second divide and the output register;
// a zero-length segment skips to the output, a point on the line stops after one divide.
// The front and the back part each take a new item only when done with the last one.
// Reset clears the running sum, the sticky flag, the queue and all valids.
`default_nettype none

module segment_obstacle_cost
   import soc_pkg::*;
#(
   parameter int COORD_BITS     = 16,
   parameter int COST_FRAC_BITS = 16
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_obstacle_x,
   input  wire logic signed [COORD_BITS-1:0] req_obstacle_y,
   input  wire logic                         req_first_of_run,
   input  wire logic                         req_last_of_run,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [COST_W-1:0]                 rsp_term_cost,
   output logic                              rsp_term_infinite,
   output logic [COST_W-1:0]                 rsp_sum_cost,
   output logic                              rsp_sum_infinite,
   output logic                              rsp_run_done
);

   logic             fe_push, be_pop;
   soc_job_type      fe_job, q_job;
   soc_q_status_type q_status;

   soc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_seg_start_x  (req_seg_start_x),
      .req_seg_start_y  (req_seg_start_y),
      .req_seg_end_x    (req_seg_end_x),
      .req_seg_end_y    (req_seg_end_y),
      .req_obstacle_x   (req_obstacle_x),
      .req_obstacle_y   (req_obstacle_y),
      .req_first_of_run (req_first_of_run),
      .req_last_of_run  (req_last_of_run),
      .push             (fe_push),
      .push_job         (fe_job),
      .q_status         (q_status)
   );

   soc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (fe_push),
      .push_job (fe_job),
      .pop      (be_pop),
      .pop_job  (q_job),
      .q_status (q_status)
   );

   soc_back #(.COST_FRAC_BITS(COST_FRAC_BITS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .job               (q_job),
      .q_status          (q_status),
      .pop               (be_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_term_cost     (rsp_term_cost),
      .rsp_term_infinite (rsp_term_infinite),
      .rsp_sum_cost      (rsp_sum_cost),
      .rsp_sum_infinite  (rsp_sum_infinite),
      .rsp_run_done      (rsp_run_done)
   );

   // an infinite term saturates its own cost and makes the run infinite
   a_term_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_term_infinite |-> rsp_term_cost == COST_MAX && rsp_sum_infinite)
      else $error("infinite term without saturated cost or sticky flag");

   // a sticky run holds the sum at its ceiling
   a_sum_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_infinite |-> rsp_sum_cost == COST_MAX)
      else $error("infinite run with unsaturated sum");

   // the running sum never falls below the term just added
   a_sum_ge: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sum_cost >= rsp_term_cost)
      else $error("running sum below term");

   // the front never pushes into a full queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      fe_push |-> !q_status.full)
      else $error("push into full queue");

endmodule

`default_nettype wire

### rtl/soc_front.sv
// soc_front: accepts an item, forms the differences and, with one shared
// multiplier, l2, cross and dot. Uses soc_pkg.
`default_nettype none

module soc_front
   import soc_pkg::*;
#(
   parameter int COORD_BITS = 16
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_seg_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_obstacle_x,
   input  wire logic signed [COORD_BITS-1:0] req_obstacle_y,
   input  wire logic                         req_first_of_run,
   input  wire logic                         req_last_of_run,
   output logic                              push,
   output soc_job_type                       push_job,
   input  wire soc_q_status_type             q_status
);

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_type;

   front_state_type          state_ff;
   logic [2:0]               step_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, px_ff, py_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0] l2_ff, cross_ff, dot_ff;
   logic                     first_ff, last_ff;

   logic signed [DIFF_W-1:0] sx, sy, ex, ey, ox, oy;
   logic signed [DIFF_W-1:0] op_a, op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [WIDE_W-1:0] prod_w;
   logic [2:0]               acc_idx;
   logic signed [WIDE_W-1:0] cross_abs;

   // sign-extend coordinates
   assign sx = DIFF_W'(req_seg_start_x);
   assign sy = DIFF_W'(req_seg_start_y);
   assign ex = DIFF_W'(req_seg_end_x);
   assign ey = DIFF_W'(req_seg_end_y);
   assign ox = DIFF_W'(req_obstacle_x);
   assign oy = DIFF_W'(req_obstacle_y);

   // operand pairs: dx.dx, dy.dy, dx.py, dy.px, dx.px, dy.py
   always_comb begin
      case (step_ff)
         3'd0: begin op_a = dx_ff; op_b = dx_ff; end
         3'd1: begin op_a = dy_ff; op_b = dy_ff; end
         3'd2: begin op_a = dx_ff; op_b = py_ff; end
         3'd3: begin op_a = dy_ff; op_b = px_ff; end
         3'd4: begin op_a = dx_ff; op_b = px_ff; end
         3'd5: begin op_a = dy_ff; op_b = py_ff; end
         default: begin op_a = dx_ff; op_b = dx_ff; end
      endcase
   end

   assign prod    = op_a * op_b;
   assign prod_w  = WIDE_W'(prod_ff);
   assign acc_idx = step_ff - 3'd1;

   assign req_stall = (state_ff != F_IDLE);

   // hand the finished job to the queue
   assign cross_abs = cross_ff[WIDE_W-1] ? -cross_ff : cross_ff;
   assign push      = (state_ff == F_PUSH) && !q_status.full;
   always_comb begin
      push_job.cross_mag  = CROSS_W'(cross_abs);
      push_job.dot        = dot_ff;
      push_job.len_sq     = l2_ff;
      push_job.degenerate = (l2_ff == '0);
      push_job.first      = first_ff;
      push_job.last       = last_ff;
   end

   // sequencer: one product per cycle, accumulated in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  dx_ff    <= ex - sx;
                  dy_ff    <= ey - sy;
                  px_ff    <= ox - sx;
                  py_ff    <= oy - sy;
                  first_ff <= req_first_of_run;
                  last_ff  <= req_last_of_run;
                  step_ff  <= '0;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff <= prod;
               if (step_ff != 3'd0) begin
                  case (acc_idx)
                     3'd0: l2_ff    <= prod_w;
                     3'd1: l2_ff    <= l2_ff + prod_w;
                     3'd2: cross_ff <= prod_w;
                     3'd3: cross_ff <= cross_ff - prod_w;
                     3'd4: dot_ff   <= prod_w;
                     3'd5: dot_ff   <= dot_ff + prod_w;
                     default: ;
                  endcase
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'(MUL_STEPS)) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!q_status.full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/soc_queue.sv
// soc_queue: short job queue between front and back parts.
// Uses soc_pkg for the job record and status types.
`default_nettype none

module soc_queue
   import soc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire soc_job_type   push_job,
   input  wire logic          pop,
   output soc_job_type        pop_job,
   output soc_q_status_type   q_status
);

   soc_job_type          entries_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_PTR_W:0]     count_ff;
   logic                 do_push, do_pop;

   assign q_status.full  = (count_ff == (Q_PTR_W+1)'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;
   assign pop_job = entries_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/soc_back.sv
// soc_back: sequencer around a square root step and a division step, both
// shift-subtract and sharing one set of registers, and one CORDIC stage; run
// accumulation and output register. Uses soc_pkg.
`default_nettype none

module soc_back
   import soc_pkg::*;
#(
   parameter int COST_FRAC_BITS = 16
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire soc_job_type        job,
   input  wire soc_q_status_type   q_status,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [COST_W-1:0]       rsp_term_cost,
   output logic                    rsp_term_infinite,
   output logic [COST_W-1:0]       rsp_sum_cost,
   output logic                    rsp_sum_infinite,
   output logic                    rsp_run_done
);

   localparam int NUM_SH = (COST_FRAC_BITS >= COST_REF) ? COST_FRAC_BITS - COST_REF : 0;
   localparam int DEN_SH = (COST_FRAC_BITS <  COST_REF) ? COST_REF - COST_FRAC_BITS : 0;

   typedef enum logic [2:0] {
      B_IDLE, B_SQRT, B_DIV_DQ, B_NORM, B_CORD, B_MUL, B_DIV_TERM, B_DONE
   } back_state_type;

   back_state_type            state_ff;
   soc_job_type               job_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [NUM_W-1:0]          quo_ff, src_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic [DQ_W-1:0]           dq_ff;
   logic signed [VEC_W-1:0]   vx_ff, vy_ff;
   logic signed [ANG_W-1:0]   z_ff, a1_ff;
   logic                      second_ff;
   logic [THETA_W-1:0]        theta_ff;
   logic [COST_W-1:0]         term_ff;
   logic                      term_inf_ff;
   logic [COST_W-1:0]         sum_ff;
   logic                      sum_inf_ff;
   logic                      rsp_valid_ff;
   logic [COST_W-1:0]         rsp_term_ff, rsp_sum_ff;
   logic                      rsp_term_inf_ff, rsp_sum_inf_ff, rsp_done_ff;

   // square root step: two radicand bits per cycle
   logic [REM_W-1:0] sq_rem2, sq_trial, sq_rem;
   logic             sq_ge;
   logic [NUM_W-1:0] sq_quo;
   assign sq_rem2  = {rem_ff[REM_W-3:0], src_ff[NUM_W-1 -: 2]};
   assign sq_trial = REM_W'({quo_ff, 2'b01});
   assign sq_ge    = (sq_rem2 >= sq_trial);
   assign sq_rem   = sq_ge ? sq_rem2 - sq_trial : sq_rem2;
   assign sq_quo   = {quo_ff[NUM_W-2:0], sq_ge};

   // restoring division step: one quotient bit per cycle
   logic [REM_W-1:0] dv_rem2, dv_den, dv_rem;
   logic             dv_ge;
   logic [NUM_W-1:0] dv_quo;
   assign dv_rem2 = {rem_ff[REM_W-2:0], src_ff[NUM_W-1]};
   assign dv_den  = REM_W'(den_ff);
   assign dv_ge   = (dv_rem2 >= dv_den);
   assign dv_rem  = dv_ge ? dv_rem2 - dv_den : dv_rem2;
   assign dv_quo  = {quo_ff[NUM_W-2:0], dv_ge};

   // vectoring CORDIC step; a zero y rotates as if negative
   logic [ANG_IDX_W-1:0]    ang_idx;
   logic signed [VEC_W-1:0] sh_x, sh_y, cx_next, cy_next;
   logic signed [ANG_W-1:0] arc, z_next;
   logic                    rot_pos;
   assign ang_idx = cnt_ff[ANG_IDX_W-1:0];
   assign sh_x    = vx_ff >>> ang_idx;
   assign sh_y    = vy_ff >>> ang_idx;
   assign arc     = arc_at(ang_idx);
   assign rot_pos = !vy_ff[VEC_W-1] && (vy_ff != '0);
   assign cx_next = rot_pos ? vx_ff + sh_y : vx_ff - sh_y;
   assign cy_next = rot_pos ? vy_ff - sh_x : vy_ff + sh_x;
   assign z_next  = rot_pos ? z_ff + arc : z_ff - arc;

   // normalisation: larger magnitude component brought up to 2^57
   logic [VEC_W-1:0] vy_mag, vx_mag, mag;
   assign vy_mag = vy_ff[VEC_W-1] ? VEC_W'(-vy_ff) : VEC_W'(vy_ff);
   assign vx_mag = VEC_W'(vx_ff);
   assign mag    = (vx_mag > vy_mag) ? vx_mag : vy_mag;

   // angle difference, clamped at zero
   logic signed [ANG_W-1:0] theta_diff;
   logic                    theta_pos;
   assign theta_diff = z_next - a1_ff;
   assign theta_pos  = (z_next > a1_ff);

   // second vector and scaled numerator
   logic signed [WIDE_W-1:0]  job_dot, job_l2, job_far;
   logic [THETA_W+SCALE_W-1:0] theta_scaled;
   assign job_dot      = job_ff.dot;
   assign job_l2       = job_ff.len_sq;
   assign job_far      = job_l2 - job_dot;
   assign theta_scaled = theta_ff * MM_PER_M;

   // saturated quotient
   logic [COST_W-1:0] term_sat;
   assign term_sat = (|dv_quo[NUM_W-1:COST_W]) ? COST_MAX : dv_quo[COST_W-1:0];

   // run accumulation
   logic [COST_W-1:0] sum_base, sum_next;
   logic              inf_base, inf_next;
   logic [COST_W:0]   sum_wide;
   assign sum_base = job_ff.first ? '0 : sum_ff;
   assign inf_base = job_ff.first ? 1'b0 : sum_inf_ff;
   assign sum_wide = {1'b0, sum_base} + {1'b0, term_ff};
   always_comb begin
      if (term_inf_ff) begin
         sum_next = COST_MAX;
         inf_next = 1'b1;
      end else begin
         sum_next = sum_wide[COST_W] ? COST_MAX : sum_wide[COST_W-1:0];
         inf_next = inf_base;
      end
   end

   logic slot_free;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == B_IDLE) && !q_status.empty;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_term_cost     = rsp_term_ff;
   assign rsp_term_infinite = rsp_term_inf_ff;
   assign rsp_sum_cost      = rsp_sum_ff;
   assign rsp_sum_infinite  = rsp_sum_inf_ff;
   assign rsp_run_done      = rsp_done_ff;

   // sequencer, state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         second_ff    <= 1'b0;
         sum_ff       <= '0;
         sum_inf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // B_DONE reloads the output register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != B_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_IDLE: begin
               if (!q_status.empty) begin
                  job_ff      <= job;
                  term_inf_ff <= job.degenerate;
                  src_ff      <= NUM_W'(unsigned'(job.len_sq)) << LEN_SHIFT;
                  rem_ff      <= '0;
                  quo_ff      <= '0;
                  cnt_ff      <= '0;
                  state_ff    <= job.degenerate ? B_DONE : B_SQRT;
               end
            end
            B_SQRT: begin
               rem_ff <= sq_rem;
               quo_ff <= sq_quo;
               src_ff <= src_ff << 2;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
                  den_ff   <= DEN_W'(sq_quo[ROOT_W-1:0]);
                  src_ff   <= NUM_W'(job_ff.cross_mag) << DIST_SHIFT;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= B_DIV_DQ;
               end
            end
            B_DIV_DQ: begin
               rem_ff <= dv_rem;
               quo_ff <= dv_quo;
               src_ff <= src_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  dq_ff     <= dv_quo[DQ_W-1:0];
                  vx_ff     <= VEC_W'(job_ff.cross_mag);
                  vy_ff     <= -(VEC_W'(job_dot));
                  second_ff <= 1'b0;
                  if (dv_quo == '0) begin
                     term_inf_ff <= 1'b1;
                     state_ff    <= B_DONE;
                  end else begin
                     state_ff <= B_NORM;
                  end
               end
            end
            B_NORM: begin
               if (mag < NORM_COARSE) begin
                  vx_ff <= vx_ff <<< NORM_COARSE_SH;
                  vy_ff <= vy_ff <<< NORM_COARSE_SH;
               end else if (mag < NORM_TARGET) begin
                  vx_ff <= vx_ff <<< 1;
                  vy_ff <= vy_ff <<< 1;
               end else begin
                  cnt_ff   <= '0;
                  z_ff     <= '0;
                  state_ff <= B_CORD;
               end
            end
            B_CORD: begin
               vx_ff  <= cx_next;
               vy_ff  <= cy_next;
               z_ff   <= z_next;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(ANG_STEPS - 1)) begin
                  if (!second_ff) begin
                     a1_ff     <= z_next;
                     vx_ff     <= VEC_W'(job_ff.cross_mag);
                     vy_ff     <= VEC_W'(job_far);
                     second_ff <= 1'b1;
                     state_ff  <= B_NORM;
                  end else begin
                     theta_ff <= theta_pos ? THETA_W'(theta_diff) : '0;
                     state_ff <= B_MUL;
                  end
               end
            end
            B_MUL: begin
               src_ff   <= NUM_W'(theta_scaled) << NUM_SH;
               den_ff   <= DEN_W'(dq_ff) << DEN_SH;
               rem_ff   <= '0;
               quo_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= B_DIV_TERM;
            end
            B_DIV_TERM: begin
               rem_ff <= dv_rem;
               quo_ff <= dv_quo;
               src_ff <= src_ff << 1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
                  term_ff  <= term_sat;
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (slot_free) begin
                  sum_ff          <= sum_next;
                  sum_inf_ff      <= inf_next;
                  rsp_term_ff     <= term_inf_ff ? COST_MAX : term_ff;
                  rsp_term_inf_ff <= term_inf_ff;
                  rsp_sum_ff      <= sum_next;
                  rsp_sum_inf_ff  <= inf_next;
                  rsp_done_ff     <= job_ff.last;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
